FILE: hdl/cbps_pkg.sv
// Shared types, constants and helpers of the cubic Bezier path sampler.
// Used by cbps_ctrl, cbps_datapath and cubic_bezier_path_sampler_top.
// Depends on nothing else.
package cbps_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int MAX_SAMPLES_DEF = 64;

  localparam logic [15:0] T_STEP_RST    = 16'd3277;
  localparam logic [15:0] STEP_TIME_RST = 16'd13;
  localparam logic [15:0] FALLBACK_STEP = 16'd3277;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_CUBE_A,
    ST_CUBE_B,
    ST_MAC,
    ST_ACC,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_SQ,
    MUL_CUBE_A,
    MUL_CUBE_B
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     store;
    logic     clear_time;
    logic     start;
    mul_sel_e mul_sel;
    logic     mac_en;
    logic [1:0] mac_idx;
    logic     acc_clr;
    logic     acc_add;
    logic     emit;
    logic     advance;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic have_prev;
    logic out_free;
    logic last;
  } status_t;

  // Rounds a Q0.48 product (optionally tripled) to a Q0.16 weight, half up.
  function automatic logic [16:0] round_weight(input logic [49:0] p, input logic triple);
    logic [51:0] s;
    s = {2'b00, p} + (triple ? {1'b0, p, 1'b0} : 52'd0) + 52'h0_0000_8000_0000;
    return s[48:32];
  endfunction

endpackage

FILE: hdl/cbps_ctrl.sv
// Sequencer of the cubic Bezier path sampler: accepts nodes and steps the
// datapath through weight, multiply-accumulate and emit phases per sample.
// Depends on cbps_pkg.
module cbps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              first_node_i,
  input  cbps_pkg::status_t status_i,
  output logic              in_ready_o,
  output cbps_pkg::cmd_t    cmd_o
);

  cbps_pkg::state_e state_q, state_d;
  logic [1:0]       mac_cnt_q, mac_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cbps_pkg::ST_IDLE;
      mac_cnt_q <= 2'd0;
    end else begin
      state_q   <= state_d;
      mac_cnt_q <= mac_cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mac_cnt_d = 2'd0;
    unique case (state_q)
      cbps_pkg::ST_IDLE: begin
        if (in_valid_i && !first_node_i && status_i.have_prev) begin
          state_d = cbps_pkg::ST_SQUARE;
        end
      end
      cbps_pkg::ST_SQUARE: state_d = cbps_pkg::ST_CUBE_A;
      cbps_pkg::ST_CUBE_A: state_d = cbps_pkg::ST_CUBE_B;
      cbps_pkg::ST_CUBE_B: state_d = cbps_pkg::ST_MAC;
      cbps_pkg::ST_MAC: begin
        mac_cnt_d = mac_cnt_q + 2'd1;
        if (mac_cnt_q == 2'd3) begin
          state_d = cbps_pkg::ST_ACC;
        end
      end
      cbps_pkg::ST_ACC: state_d = cbps_pkg::ST_EMIT;
      cbps_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.last ? cbps_pkg::ST_IDLE : cbps_pkg::ST_SQUARE;
        end
      end
      default: state_d = cbps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = cbps_pkg::MUL_NONE;
    in_ready_o    = 1'b0;
    unique case (state_q)
      cbps_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (first_node_i || !status_i.have_prev) begin
            cmd_o.store      = 1'b1;
            cmd_o.clear_time = first_node_i;
          end else begin
            cmd_o.start = 1'b1;
          end
        end
      end
      cbps_pkg::ST_SQUARE: cmd_o.mul_sel = cbps_pkg::MUL_SQ;
      cbps_pkg::ST_CUBE_A: cmd_o.mul_sel = cbps_pkg::MUL_CUBE_A;
      cbps_pkg::ST_CUBE_B: cmd_o.mul_sel = cbps_pkg::MUL_CUBE_B;
      cbps_pkg::ST_MAC: begin
        cmd_o.mac_en  = 1'b1;
        cmd_o.mac_idx = mac_cnt_q;
        cmd_o.acc_clr = (mac_cnt_q == 2'd0);
        cmd_o.acc_add = (mac_cnt_q != 2'd0);
      end
      cbps_pkg::ST_ACC: cmd_o.acc_add = 1'b1;
      cbps_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.commit  = status_i.last;
          cmd_o.advance = !status_i.last;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: hdl/cbps_datapath.sv
// Datapath of the cubic Bezier path sampler: node registers, Bernstein weight
// unit with two multipliers, per-axis multiply-accumulate, output register.
// Depends on cbps_pkg.
module cbps_datapath #(
  parameter int COORD_BITS  = cbps_pkg::COORD_BITS_DEF,
  parameter int MAX_SAMPLES = cbps_pkg::MAX_SAMPLES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cbps_pkg::cmd_t          cmd_i,
  output cbps_pkg::status_t       status_o,
  input  logic [9*COORD_BITS-1:0] node_data_i,
  input  logic [15:0]             t_step_i,
  input  logic [15:0]             step_time_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [3*COORD_BITS-1:0] out_pos_o,
  output logic [31:0]             out_time_o,
  output logic                    out_last_o
);

  localparam int PW = COORD_BITS + 18;
  localparam int AW = COORD_BITS + 20;
  localparam int RW = AW - 16;
  localparam int KW = $clog2(MAX_SAMPLES);
  localparam logic signed [RW-1:0] SAT_HI = {{(RW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = {{(RW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

  logic signed [COORD_BITS-1:0] cur_pt_q [3];
  logic signed [COORD_BITS-1:0] cur_en_q [3];
  logic signed [COORD_BITS-1:0] cur_ex_q [3];
  logic signed [COORD_BITS-1:0] prev_pt_q [3];
  logic signed [COORD_BITS-1:0] prev_ex_q [3];
  logic                         have_prev_q;

  logic [15:0]   t_q;
  logic [KW-1:0] k_q;
  logic [31:0]   elapsed_q;
  logic [15:0]   step_eff;
  logic [16:0]   t_sum;
  logic [16:0]   u;

  logic [32:0] u2_q;
  logic [31:0] t2_q;
  logic [16:0] w_q [4];
  logic [32:0] ma0, ma1;
  logic [16:0] mb0, mb1;
  logic [49:0] mp0, mp1;

  logic signed [COORD_BITS-1:0] coef [3];
  logic [16:0]                  w_sel;
  logic signed [PW-1:0]         prod_d [3];
  logic signed [PW-1:0]         prod_q [3];
  logic signed [AW-1:0]         acc_q [3];
  logic signed [AW-1:0]         rnd_sum [3];
  logic signed [RW-1:0]         rnd [3];
  logic [COORD_BITS-1:0]        sat [3];

  logic [COORD_BITS-1:0] out_pos_q [3];
  logic [31:0]           out_time_q;
  logic                  out_last_q;
  logic                  out_valid_q;

  assign step_eff = (t_step_i == 16'd0) ? cbps_pkg::FALLBACK_STEP : t_step_i;
  assign t_sum    = {1'b0, t_q} + {1'b0, step_eff};
  assign u        = 17'h1_0000 - {1'b0, t_q};

  assign status_o.have_prev = have_prev_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.last      = t_sum[16] || (k_q == KW'(MAX_SAMPLES - 1));

  always_comb begin
    unique case (cmd_i.mul_sel)
      cbps_pkg::MUL_SQ: begin
        ma0 = {16'd0, u};
        mb0 = u;
        ma1 = {17'd0, t_q};
        mb1 = {1'b0, t_q};
      end
      cbps_pkg::MUL_CUBE_A: begin
        ma0 = u2_q;
        mb0 = u;
        ma1 = u2_q;
        mb1 = {1'b0, t_q};
      end
      cbps_pkg::MUL_CUBE_B: begin
        ma0 = {1'b0, t2_q};
        mb0 = u;
        ma1 = {1'b0, t2_q};
        mb1 = {1'b0, t_q};
      end
      cbps_pkg::MUL_NONE: begin
        ma0 = '0;
        mb0 = '0;
        ma1 = '0;
        mb1 = '0;
      end
    endcase
  end

  assign mp0 = 50'(ma0) * 50'(mb0);
  assign mp1 = 50'(ma1) * 50'(mb1);
  assign w_sel = w_q[cmd_i.mac_idx];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (cmd_i.mac_idx)
        2'd0: coef[i] = prev_pt_q[i];
        2'd1: coef[i] = prev_ex_q[i];
        2'd2: coef[i] = cur_en_q[i];
        2'd3: coef[i] = cur_pt_q[i];
      endcase
      prod_d[i]  = PW'(coef[i]) * PW'($signed({1'b0, w_sel}));
      rnd_sum[i] = acc_q[i] + AW'(32768);
      rnd[i]     = rnd_sum[i][AW-1:16];
      if (rnd[i] > SAT_HI) begin
        sat[i] = SAT_HI[COORD_BITS-1:0];
      end else if (rnd[i] < SAT_LO) begin
        sat[i] = SAT_LO[COORD_BITS-1:0];
      end else begin
        sat[i] = rnd[i][COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd_i.load) begin
        cur_pt_q[i] <= node_data_i[i*COORD_BITS +: COORD_BITS];
        cur_en_q[i] <= node_data_i[(3+i)*COORD_BITS +: COORD_BITS];
        cur_ex_q[i] <= node_data_i[(6+i)*COORD_BITS +: COORD_BITS];
      end
      if (cmd_i.store) begin
        prev_pt_q[i] <= node_data_i[i*COORD_BITS +: COORD_BITS];
        prev_ex_q[i] <= node_data_i[(6+i)*COORD_BITS +: COORD_BITS];
      end else if (cmd_i.commit) begin
        prev_pt_q[i] <= cur_pt_q[i];
        prev_ex_q[i] <= cur_ex_q[i];
      end
      if (cmd_i.mac_en) begin
        prod_q[i] <= prod_d[i];
      end
      if (cmd_i.acc_clr) begin
        acc_q[i] <= '0;
      end else if (cmd_i.acc_add) begin
        acc_q[i] <= acc_q[i] + AW'(prod_q[i]);
      end
      if (cmd_i.emit) begin
        out_pos_q[i] <= sat[i];
      end
    end
    if (cmd_i.emit) begin
      out_time_q <= elapsed_q;
      out_last_q <= status_o.last;
    end
    unique case (cmd_i.mul_sel)
      cbps_pkg::MUL_SQ: begin
        u2_q <= mp0[32:0];
        t2_q <= mp1[31:0];
      end
      cbps_pkg::MUL_CUBE_A: begin
        w_q[0] <= cbps_pkg::round_weight(mp0, 1'b0);
        w_q[1] <= cbps_pkg::round_weight(mp1, 1'b1);
      end
      cbps_pkg::MUL_CUBE_B: begin
        w_q[2] <= cbps_pkg::round_weight(mp0, 1'b1);
        w_q[3] <= cbps_pkg::round_weight(mp1, 1'b0);
      end
      cbps_pkg::MUL_NONE: begin
      end
    endcase
    if (cmd_i.start) begin
      t_q <= 16'd0;
      k_q <= '0;
    end else if (cmd_i.advance) begin
      t_q <= t_sum[15:0];
      k_q <= k_q + KW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      elapsed_q   <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.store) begin
        have_prev_q <= 1'b1;
      end
      if (cmd_i.clear_time) begin
        elapsed_q <= 32'd0;
      end else if (cmd_i.emit) begin
        elapsed_q <= elapsed_q + {8'd0, step_time_i, 8'd0};
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pos_o   = {out_pos_q[2], out_pos_q[1], out_pos_q[0]};
  assign out_time_o  = out_time_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: hdl/cubic_bezier_path_sampler_top.sv
// Top level of the cubic Bezier path sampler: stream ports, register port,
// controller and datapath. Depends on cbps_pkg, cbps_ctrl and cbps_datapath.
//
// Nodes arrive on the slave stream. A first node, or any node while no
// previous node is held, is stored and gives no sample. Every other node
// samples the segment from the previous node, and each sample passes through
// one squaring step and two cubing steps in the two-multiplier weight unit,
// four multiply-accumulate steps, one accumulate step and the emit into the
// output register. The reset step gives 20 samples per segment, and the emit
// waits while the output register is still full. The next node is accepted
// in the cycle after the last sample enters the output register.
module cubic_bezier_path_sampler_top #(
  parameter int COORD_BITS  = cbps_pkg::COORD_BITS_DEF,
  parameter int MAX_SAMPLES = cbps_pkg::MAX_SAMPLES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // point_x, point_y, point_z, entry_x, entry_y, entry_z, exit_x, exit_y, exit_z
  input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // first_node
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pos_x, pos_y, pos_z, sample_time
  output logic [((3*COORD_BITS+32+7)/8)*8-1:0] m_axis_tdata,
  // last_sample
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int OUT_W = ((3*COORD_BITS+32+7)/8)*8;
  localparam logic REG_T_STEP    = 1'b0;
  localparam logic REG_STEP_TIME = 1'b1;

  logic [15:0] t_step_q;
  logic [15:0] step_time_q;
  logic        cfg_wr;

  cbps_pkg::cmd_t    cmd;
  cbps_pkg::status_t status;

  logic [3*COORD_BITS-1:0] out_pos;
  logic [31:0]             out_time;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_step_q    <= cbps_pkg::T_STEP_RST;
      step_time_q <= cbps_pkg::STEP_TIME_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_T_STEP:    t_step_q    <= pwdata[15:0];
        REG_STEP_TIME: step_time_q <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_T_STEP:    prdata = {16'd0, t_step_q};
      REG_STEP_TIME: prdata = {16'd0, step_time_q};
    endcase
  end

  cbps_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .first_node_i (s_axis_tuser),
    .status_i     (status),
    .in_ready_o   (s_axis_tready),
    .cmd_o        (cmd)
  );

  cbps_datapath #(
    .COORD_BITS  (COORD_BITS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .node_data_i (s_axis_tdata[9*COORD_BITS-1:0]),
    .t_step_i    (t_step_q),
    .step_time_i (step_time_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_pos_o   (out_pos),
    .out_time_o  (out_time),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({out_time, out_pos});

endmodule
